### rtl/flagged_rle_lz_byte_decompressor_assert.svh
// Assertion macros for the flagged RLE/LZ byte decompressor.
// Taken in by the RTL files that check their own logic; no other dependencies.
`ifndef FLAGGED_RLE_LZ_BYTE_DECOMPRESSOR_ASSERT_SVH
`define FLAGGED_RLE_LZ_BYTE_DECOMPRESSOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define FRLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frld check failed");
// Next-cycle implication, disabled in reset
`define FRLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frld check failed");
`else
`define FRLD_ASSERT_IMP(label, clk, rst, ante, cons)
`define FRLD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/frld_pkg.sv
// Shared types and constants of the flagged RLE/LZ byte decompressor.
// No dependencies; used by frld_decode and the top level.
`default_nettype none

package frld_pkg;

   // Input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Command byte top-nibble codes
   localparam logic [3:0] CMD_RUN_SHORT = 4'd0;
   localparam logic [3:0] CMD_RUN_LONG  = 4'd1;
   localparam logic [3:0] CMD_COPY_LONG = 4'd2;

   // Length and distance biases
   localparam logic [12:0] SHORT_BIAS = 13'd3;
   localparam logic [12:0] LONG_BIAS  = 13'd16;

   // Tokens per control word
   localparam logic [4:0] CTRL_WORD_BITS = 5'd16;

   // One decoded item on its way to the history write and the result register
   typedef struct packed {
      logic        emit;      // item produces a decompressed byte
      logic        from_mem;  // byte comes from the history read
      logic [7:0]  byte_val;  // byte when not read from history
      logic [15:0] wr_pos;    // output position of the byte
      logic        want;
      logic        err;
      logic        fin;
   } frld_item_type;

endpackage

`default_nettype wire

### rtl/frld_decode.sv
// Token decoder and stream state of the flagged RLE/LZ byte decompressor.
// Uses frld_pkg and the assertion macro header; feeds the history memory.
`default_nettype none
`include "flagged_rle_lz_byte_decompressor_assert.svh"

module frld_decode (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_kind,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic [15:0]            output_size,
   input  wire logic                   adv,
   output logic                        s1_valid,
   output frld_pkg::frld_item_type     s1_item,
   output logic                        rd_en,
   output logic [15:0]                 rd_pos
);
   import frld_pkg::*;

   typedef enum logic [2:0] {
      PH_TOKEN,
      PH_CTRL_HI,
      PH_ARG1,
      PH_FILL,
      PH_LEN,
      PH_DRAIN
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [15:0]   produced_ff, produced_in;
   logic [15:0]   bits_ff, bits_in;
   logic [4:0]    pos_ff, pos_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [12:0]   pend_ff, pend_in;
   logic [12:0]   dist_ff, dist_in;
   logic [7:0]    fill_ff, fill_in;
   logic          err_ff, err_in;
   logic          s1_valid_ff, s1_valid_in;
   frld_item_type s1_item_ff, s1_item_in;

   logic          accept;
   logic [4:0]    pos_dec;
   logic [12:0]   lo_len;
   logic [12:0]   b_shift;
   logic [12:0]   tok_len;
   logic          start_run;
   logic          start_copy;
   logic          overrun;
   logic          fin;

   // Take a new item when stage one is empty or moving on
   assign req_stall = s1_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   assign pos_dec = pos_ff - 5'd1;
   assign lo_len  = {9'd0, cmd_ff[3:0]} + SHORT_BIAS;
   assign b_shift = {1'b0, req_data_byte, 4'h0};
   assign rd_pos  = produced_ff - {3'b000, dist_ff};

   // Decode one item against the current stream state
   always_comb begin
      phase_in    = phase_ff;
      produced_in = produced_ff;
      bits_in     = bits_ff;
      pos_in      = pos_ff;
      cmd_in      = cmd_ff;
      pend_in     = pend_ff;
      dist_in     = dist_ff;
      fill_in     = fill_ff;
      err_in      = err_ff;
      rd_en       = 1'b0;
      start_run   = 1'b0;
      start_copy  = 1'b0;
      tok_len     = '0;
      s1_item_in  = s1_item_ff;
      s1_item_in.emit     = 1'b0;
      s1_item_in.from_mem = 1'b0;
      s1_item_in.byte_val = 8'h00;
      s1_item_in.wr_pos   = produced_ff;

      if (accept && !err_ff) begin
         if (req_kind == KIND_BYTE) begin
            case (phase_ff)
               PH_TOKEN: begin
                  if (produced_ff >= output_size) begin
                     err_in = 1'b1;
                  end else if (pos_ff == 5'd0) begin
                     bits_in  = {8'h00, req_data_byte};
                     phase_in = PH_CTRL_HI;
                  end else begin
                     pos_in = pos_dec;
                     if (!bits_ff[pos_dec[3:0]]) begin
                        // literal byte goes straight out
                        s1_item_in.emit     = 1'b1;
                        s1_item_in.byte_val = req_data_byte;
                        produced_in         = produced_ff + 16'd1;
                     end else begin
                        cmd_in = req_data_byte;
                        if (req_data_byte[7:4] == CMD_RUN_SHORT) begin
                           start_run = 1'b1;
                           tok_len   = {9'd0, req_data_byte[3:0]} + SHORT_BIAS;
                        end else begin
                           phase_in = PH_ARG1;
                        end
                     end
                  end
               end
               PH_CTRL_HI: begin
                  bits_in  = {req_data_byte, bits_ff[7:0]};
                  pos_in   = CTRL_WORD_BITS;
                  phase_in = PH_TOKEN;
               end
               PH_ARG1: begin
                  if (cmd_ff[7:4] == CMD_RUN_LONG) begin
                     start_run = 1'b1;
                     tok_len   = lo_len + b_shift + LONG_BIAS;
                  end else begin
                     dist_in = lo_len + b_shift;
                     if (cmd_ff[7:4] == CMD_COPY_LONG) begin
                        phase_in = PH_LEN;
                     end else begin
                        start_copy = 1'b1;
                        tok_len    = {9'd0, cmd_ff[7:4]};
                     end
                  end
               end
               PH_FILL: begin
                  fill_in  = req_data_byte;
                  phase_in = PH_DRAIN;
               end
               PH_LEN: begin
                  start_copy = 1'b1;
                  tok_len    = {5'd0, req_data_byte} + LONG_BIAS;
               end
               default: begin
                  // draining: the byte is taken with no change
               end
            endcase
         end else if (phase_ff == PH_DRAIN) begin
            // drain one run or copy byte
            s1_item_in.emit = 1'b1;
            if (cmd_ff[7:4] <= CMD_RUN_LONG) begin
               s1_item_in.byte_val = fill_ff;
            end else begin
               s1_item_in.from_mem = 1'b1;
               rd_en               = 1'b1;
            end
            produced_in = produced_ff + 16'd1;
            pend_in     = pend_ff - 13'd1;
            if (pend_ff == 13'd1) begin
               phase_in = PH_TOKEN;
            end
         end
      end

      // Check the token length against the configured size
      overrun = ({1'b0, produced_ff} + {4'd0, tok_len}) > {1'b0, output_size};
      if (start_run) begin
         if (overrun) begin
            err_in = 1'b1;
         end else begin
            pend_in  = tok_len;
            phase_in = PH_FILL;
         end
      end
      if (start_copy) begin
         if (overrun || ({3'b000, dist_in} > produced_ff)) begin
            err_in = 1'b1;
         end else begin
            pend_in  = tok_len;
            phase_in = PH_DRAIN;
         end
      end

      fin = !err_in && (phase_in == PH_TOKEN) && (produced_in >= output_size);
      s1_item_in.fin  = fin;
      s1_item_in.err  = err_in;
      s1_item_in.want = !err_in && !fin && (phase_in != PH_DRAIN);

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Hold stream state and stage-one item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TOKEN;
         produced_ff <= '0;
         bits_ff     <= '0;
         pos_ff      <= '0;
         cmd_ff      <= '0;
         pend_ff     <= '0;
         dist_ff     <= '0;
         fill_ff     <= '0;
         err_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         produced_ff <= produced_in;
         bits_ff     <= bits_in;
         pos_ff      <= pos_in;
         cmd_ff      <= cmd_in;
         pend_ff     <= pend_in;
         dist_ff     <= dist_in;
         fill_ff     <= fill_in;
         err_ff      <= err_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

   // Copy reads stay at least three bytes back, clear of the write in flight
   `FRLD_ASSERT_IMP(a_copy_dist, clock, reset,
      (phase_ff == PH_DRAIN) && (cmd_ff[7:4] >= CMD_COPY_LONG), dist_ff >= SHORT_BIAS)
   // A pending run or copy always has bytes left
   `FRLD_ASSERT_IMP(a_pend_live, clock, reset,
      (phase_ff == PH_DRAIN) || (phase_ff == PH_FILL), pend_ff != 13'd0)
   // The error latch never clears
   `FRLD_ASSERT_NXT(a_err_sticky, clock, reset, err_ff, err_ff)

endmodule

`default_nettype wire

### rtl/flagged_rle_lz_byte_decompressor.sv
// Top level of the flagged RLE/LZ byte decompressor: history memory and result register.
// Uses frld_pkg and frld_decode.
//
//   channel   ports                                      direction
//   req       req_valid req_stall req_kind req_data_byte in
//   rsp       rsp_valid rsp_stall rsp_out_valid rsp_out_byte
//             rsp_want_byte rsp_error_flag rsp_finished  out
//   csr       csr_wr_en csr_wr_data (output_size)        in
//
// One item per cycle unless the result stalls; each item is registered in stage one,
// then in the result register. A copy byte reads the history memory at the accept edge
// and writes the byte back when the item leaves stage one, which a result stall delays.
// Reset is synchronous; the history memory is not cleared and needs no pass.
// A stalled result holds the result register and, through it, the decoder.
`default_nettype none

module flagged_rle_lz_byte_decompressor #(
   parameter int WINDOW_DEPTH = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_out_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_want_byte,
   output logic             rsp_error_flag,
   output logic             rsp_finished,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import frld_pkg::*;

   localparam int ADDR_W = $clog2(WINDOW_DEPTH);

   logic [15:0]   output_size_ff;
   logic          adv;
   logic          s1_valid;
   frld_item_type s1_item;
   logic          rd_en;
   logic [15:0]   rd_pos;
   logic [7:0]    rd_data_ff;
   logic [7:0]    hist_mem [WINDOW_DEPTH];
   logic          wr_en;
   logic [7:0]    wr_data;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          want_ff;
   logic          err_ff;
   logic          fin_ff;

   // Hold the size register
   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff <= '0;
      end else if (csr_wr_en) begin
         output_size_ff <= csr_wr_data;
      end
   end

   frld_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .output_size   (output_size_ff),
      .adv           (adv),
      .s1_valid      (s1_valid),
      .s1_item       (s1_item),
      .rd_en         (rd_en),
      .rd_pos        (rd_pos)
   );

   // Stage one moves on when the result register is free or being taken
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign wr_en   = s1_valid && adv && s1_item.emit;
   assign wr_data = s1_item.from_mem ? rd_data_ff : s1_item.byte_val;

   // History window: read at accept, write back the produced byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[s1_item.wr_pos[ADDR_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_pos[ADDR_W-1:0]];
      end
   end

   // Advance the result register
   always_comb begin
      if (s1_valid && adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_valid && adv) begin
         out_valid_ff <= s1_item.emit;
         out_byte_ff  <= wr_data;
         want_ff      <= s1_item.want;
         err_ff       <= s1_item.err;
         fin_ff       <= s1_item.fin;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_want_byte  = want_ff;
   assign rsp_error_flag = err_ff;
   assign rsp_finished   = fin_ff;

endmodule

`default_nettype wire
